### hw/rtl/ccrc_pkg.sv
package ccrc_pkg;

    // Curve resolution.
    localparam int COS_TABLE_ENTRIES = 256;
    localparam int RATIO_FRAC_BITS   = 15;

    // Time of day.
    localparam int DAY_SECONDS   = 86400;
    localparam int HALF_DAY      = DAY_SECONDS / 2;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int SOD_W         = 17;

    // Field widths.
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int PCT_W     = 7;
    localparam int PCT_MAX   = 100;
    localparam int RATIO_W   = 16;
    localparam int RATIO_MAX = 32768;
    localparam int APPLY_DELTA = 16;

    // Curve arithmetic.
    localparam int COS_W   = RATIO_FRAC_BITS + 1;
    localparam int ONE     = 1 << RATIO_FRAC_BITS;
    localparam int COS_SH  = 30 - RATIO_FRAC_BITS;
    localparam longint unsigned COS_HALF = (64'd1 << COS_SH) >> 1;
    localparam longint unsigned PI_Q30   = 64'hC90FDAA2;
    localparam longint unsigned COS_TAB_DIV = 2 * COS_TABLE_ENTRIES;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLEST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMEST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT  = 3'd4;

    localparam logic [SOD_W-1:0] RST_COOLEST = 17'd39600;
    localparam logic [SOD_W-1:0] RST_WARMEST = 17'd82800;
    localparam logic [SOD_W-1:0] RST_RAMP    = 17'd3600;
    localparam logic [PCT_W-1:0] RST_MIN_PCT = 7'd0;
    localparam logic [PCT_W-1:0] RST_MAX_PCT = 7'd100;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                clock_valid;
    } t_in_word;

    typedef struct packed {
        logic [RATIO_W-1:0] cool_ratio;
        logic               apply;
    } t_out_word;

    typedef logic [COS_W-1:0] t_cos_tab [0:COS_TABLE_ENTRIES];
    typedef logic [COS_W-1:0] t_pct_tab [0:PCT_MAX];

    // Quarter-wave cosine, entry i = cos(i*pi/(2*N)) in Q(RATIO_FRAC_BITS),
    // from an eleven-term Taylor series in Q30.
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint          sum;
        longint unsigned ii;
        for (int i = 0; i <= COS_TABLE_ENTRIES; i++) begin
            ii  = longint'(i);
            x   = (ii * PI_Q30 + longint'(COS_TABLE_ENTRIES)) / COS_TAB_DIV;
            x2  = (x * x + (64'd1 << 29)) >> 30;
            mag = 64'd1 << 30;
            sum = longint'(64'd1 << 30);
            mag = ((mag * x2) >> 30) / 2;   sum = sum - longint'(mag);
            mag = ((mag * x2) >> 30) / 12;  sum = sum + longint'(mag);
            mag = ((mag * x2) >> 30) / 30;  sum = sum - longint'(mag);
            mag = ((mag * x2) >> 30) / 56;  sum = sum + longint'(mag);
            mag = ((mag * x2) >> 30) / 90;  sum = sum - longint'(mag);
            mag = ((mag * x2) >> 30) / 132; sum = sum + longint'(mag);
            mag = ((mag * x2) >> 30) / 182; sum = sum - longint'(mag);
            mag = ((mag * x2) >> 30) / 240; sum = sum + longint'(mag);
            mag = ((mag * x2) >> 30) / 306; sum = sum - longint'(mag);
            mag = ((mag * x2) >> 30) / 380; sum = sum + longint'(mag);
            if (sum < 0) begin
                sum = 0;
            end
            tab[i] = COS_W'((longint'(sum) + longint'(COS_HALF)) >> COS_SH);
        end
        return tab;
    endfunction

    // Percent to fraction, rounded to nearest.
    function automatic t_pct_tab build_pct_tab();
        t_pct_tab        tab;
        longint unsigned v;
        for (int p = 0; p <= PCT_MAX; p++) begin
            v      = (longint'(p) * longint'(ONE) + 64'd50) / 100;
            tab[p] = COS_W'(v);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();
    localparam t_pct_tab PCT_TAB = build_pct_tab();

endpackage

### hw/rtl/circadian_cool_ratio_curve_top.sv
// Circadian cool-ratio curve: each input word carries a wall-clock time and a
// clock-valid flag, and gives one output word with the cool-channel share in
// Q1.15 and an apply flag. The block works on one word at a time and stalls
// its input meanwhile. On a cosine section a word passes through the
// shared bit-serial divider that finds the table position one quotient bit a
// cycle; on the warm hold or the zero-length ramp step the divider is skipped.
// The next word is taken as soon as the previous one has moved to the output
// register, even while that result is stalled.
// Configuration registers are to be written by the user only while no word
// is in flight; the block itself does not enforce this.
module circadian_cool_ratio_curve_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  ccrc_pkg::t_in_word                  i_data,
    output logic                                o_stall,
    output logic                                o_valid,
    output ccrc_pkg::t_out_word                 o_data,
    input  logic                                i_stall,
    input  logic                                i_cfg_valid,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_cfg_ready
);

    localparam int F       = ccrc_pkg::RATIO_FRAC_BITS;
    localparam int N       = ccrc_pkg::COS_TABLE_ENTRIES;
    localparam int SOD_W   = ccrc_pkg::SOD_W;
    localparam int COS_W   = ccrc_pkg::COS_W;
    localparam int FRAC_W  = 16;
    localparam int QUARTER = N << FRAC_W;
    localparam int TWO_Q   = 2 * QUARTER;
    localparam int POS_W   = $clog2(TWO_Q + 1);
    localparam int NUM_W   = SOD_W + POS_W;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int IDX_W   = $clog2(N + 1);
    localparam int PROD_W  = COS_W + FRAC_W;
    localparam int PROD2_W = 2 * COS_W;
    localparam int SH_R    = (F >= 15) ? F - 15 : 0;
    localparam int SH_L    = (F < 15) ? 15 - F : 0;
    localparam int Q_RND   = (1 << SH_R) >> 1;
    localparam int QT_W    = COS_W + 2 + SH_L;
    localparam int RW      = ccrc_pkg::RATIO_W;

    localparam logic [SOD_W-1:0] DAY  = SOD_W'(ccrc_pkg::DAY_SECONDS);
    localparam logic [SOD_W-1:0] HALF = SOD_W'(ccrc_pkg::HALF_DAY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_FWD,
        S_CLAMP,
        S_HOLD,
        S_SELECT,
        S_DIV,
        S_FOLD,
        S_TAB_A,
        S_TAB_B,
        S_INTERP,
        S_COSV,
        S_SCALE,
        S_ROUND,
        S_FIN
    } t_state;

    t_state r_state;

    // Configuration.
    logic [SOD_W-1:0]              r_cfg_coolest;
    logic [SOD_W-1:0]              r_cfg_warmest;
    logic [SOD_W-1:0]              r_cfg_ramp;
    logic [ccrc_pkg::PCT_W-1:0]    r_cfg_min_pct;
    logic [ccrc_pkg::PCT_W-1:0]    r_cfg_max_pct;

    // Per-word working registers.
    logic [SOD_W-1:0]  r_sod;
    logic              r_clk_valid;
    logic [SOD_W-1:0]  r_cool;
    logic [SOD_W-1:0]  r_warm;
    logic              r_eq;
    logic [SOD_W-1:0]  r_gap;
    logic [SOD_W-1:0]  r_el;
    logic [SOD_W-1:0]  r_dc;
    logic [SOD_W-1:0]  r_dfold;
    logic [SOD_W-1:0]  r_ramp;
    logic [SOD_W-1:0]  r_hold;
    logic [COS_W-1:0]  r_lo;
    logic [COS_W-1:0]  r_hi;
    logic              r_rising;
    logic [SOD_W-1:0]  r_den;
    logic [SOD_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_nq;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_q2;
    logic [IDX_W-1:0]  r_idx;
    logic [FRAC_W-1:0] r_frac;
    logic [COS_W-1:0]  r_ta;
    logic [COS_W-1:0]  r_tb;
    logic [PROD_W-1:0] r_prod;
    logic [COS_W-1:0]  r_base;
    logic [PROD2_W-1:0] r_prod2;
    logic [RW-1:0]     r_q15;

    // State carried between words, and the output register.
    logic [RW-1:0]       r_last_ratio;
    logic                r_have_applied;
    logic                r_out_valid;
    ccrc_pkg::t_out_word r_out;

    function automatic logic [SOD_W-1:0] fwd_dist(input logic [SOD_W-1:0] from,
                                                  input logic [SOD_W-1:0] to);
        logic [SOD_W:0] wrap;
        wrap = {1'b0, to} + {1'b0, DAY} - {1'b0, from};
        return (to >= from) ? to - from : wrap[SOD_W-1:0];
    endfunction

    function automatic logic [SOD_W-1:0] day_mod(input logic [SOD_W-1:0] x);
        return (x >= DAY) ? x - DAY : x;
    endfunction

    // Combinational helpers.
    logic [SOD_W-1:0]  sod_raw;
    logic [ccrc_pkg::PCT_W-1:0] min_pct_c;
    logic [ccrc_pkg::PCT_W-1:0] max_pct_c;
    logic              sel_div;
    logic [COS_W-1:0]  sel_base;
    logic [SOD_W-1:0]  sel_num;
    logic [SOD_W-1:0]  sel_den;
    logic              sel_rising;
    logic [SOD_W:0]    div_t;
    logic              div_ge;
    logic [POS_W-1:0]  pos_c;
    logic              pos_q2;
    logic [POS_W-1:0]  pos_fold;
    logic              idx_sat;
    logic [IDX_W-1:0]  tab_idx;
    logic [COS_W-1:0]  tab_val;
    logic [COS_W-1:0]  b_min;
    logic [PROD_W-1:0] interp;
    logic [COS_W-1:0]  cos_mag;
    logic [COS_W:0]    base_sum;
    logic [COS_W:0]    ratio;
    logic [QT_W-1:0]   q_tmp;
    logic [RW-1:0]     apply_diff;
    logic              apply_now;
    logic              slot_free;

    always_comb begin
        sod_raw = SOD_W'(i_data.hour) * SOD_W'(ccrc_pkg::SEC_PER_HOUR)
                + SOD_W'(i_data.minute) * SOD_W'(ccrc_pkg::SEC_PER_MIN)
                + SOD_W'(i_data.second);

        min_pct_c = (r_cfg_min_pct > ccrc_pkg::PCT_W'(ccrc_pkg::PCT_MAX))
                  ? ccrc_pkg::PCT_W'(ccrc_pkg::PCT_MAX) : r_cfg_min_pct;
        max_pct_c = (r_cfg_max_pct > ccrc_pkg::PCT_W'(ccrc_pkg::PCT_MAX))
                  ? ccrc_pkg::PCT_W'(ccrc_pkg::PCT_MAX) : r_cfg_max_pct;

        // Pick the curve section. Flat sections bypass the divider.
        sel_div    = 1'b1;
        sel_base   = '0;
        sel_num    = r_dfold;
        sel_den    = HALF;
        sel_rising = 1'b0;
        if (r_eq) begin
            sel_div = 1'b1;
        end else if (r_el < r_hold) begin
            sel_div = 1'b0;
        end else if (r_el <= r_gap) begin
            if (r_ramp == '0) begin
                sel_div  = 1'b0;
                sel_base = COS_W'(ccrc_pkg::ONE);
            end else begin
                sel_num    = r_el - r_hold;
                sel_den    = r_ramp;
                sel_rising = 1'b1;
            end
        end else begin
            sel_num = r_el - r_gap;
            sel_den = DAY - r_gap;
        end

        // One restoring-division step.
        div_t  = {r_rem, r_nq[NUM_W-1]};
        div_ge = div_t >= {1'b0, r_den};

        pos_c    = (r_nq[POS_W-1:0] > POS_W'(TWO_Q)) ? POS_W'(TWO_Q) : r_nq[POS_W-1:0];
        pos_q2   = pos_c > POS_W'(QUARTER);
        pos_fold = pos_q2 ? POS_W'(TWO_Q) - pos_c : pos_c;

        idx_sat = r_idx >= IDX_W'(N);
        tab_idx = (r_state == S_TAB_B && !idx_sat) ? IDX_W'(r_idx + 1'b1) : r_idx;
        tab_val = ccrc_pkg::COS_TAB[tab_idx];

        b_min   = (r_tb > r_ta) ? r_ta : r_tb;
        interp  = (r_prod + PROD_W'(1 << (FRAC_W - 1))) >> FRAC_W;
        cos_mag = idx_sat ? r_ta : r_ta - COS_W'(interp);
        // The raised cosine subtracts when exactly one of "second quarter"
        // and "rising ramp" holds.
        if (r_q2 ^ r_rising) begin
            base_sum = (COS_W + 1)'(ccrc_pkg::ONE) - {1'b0, cos_mag} + 1'b1;
        end else begin
            base_sum = (COS_W + 1)'(ccrc_pkg::ONE) + {1'b0, cos_mag} + 1'b1;
        end

        ratio = {1'b0, r_lo}
              + (COS_W + 1)'((r_prod2 + PROD2_W'(ccrc_pkg::ONE / 2)) >> F);
        q_tmp = ((QT_W'(ratio) + QT_W'(Q_RND)) >> SH_R) << SH_L;

        apply_diff = (r_q15 >= r_last_ratio) ? r_q15 - r_last_ratio
                                             : r_last_ratio - r_q15;
        apply_now  = r_clk_valid
                  && (!r_have_applied || apply_diff >= RW'(ccrc_pkg::APPLY_DELTA));
        slot_free  = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_coolest  <= ccrc_pkg::RST_COOLEST;
            r_cfg_warmest  <= ccrc_pkg::RST_WARMEST;
            r_cfg_ramp     <= ccrc_pkg::RST_RAMP;
            r_cfg_min_pct  <= ccrc_pkg::RST_MIN_PCT;
            r_cfg_max_pct  <= ccrc_pkg::RST_MAX_PCT;
            r_last_ratio   <= '0;
            r_have_applied <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ccrc_pkg::CFG_COOLEST: r_cfg_coolest <= i_cfg_data;
                    ccrc_pkg::CFG_WARMEST: r_cfg_warmest <= i_cfg_data;
                    ccrc_pkg::CFG_RAMP:    r_cfg_ramp    <= i_cfg_data;
                    ccrc_pkg::CFG_MIN_PCT: r_cfg_min_pct <= i_cfg_data[ccrc_pkg::PCT_W-1:0];
                    ccrc_pkg::CFG_MAX_PCT: r_cfg_max_pct <= i_cfg_data[ccrc_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end

            // A word leaving in the same cycle as the next one arrives is
            // handled in S_FIN.
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sod       <= day_mod(sod_raw);
                        r_clk_valid <= i_data.clock_valid;
                        r_state     <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    r_cool  <= day_mod(r_cfg_coolest);
                    r_warm  <= day_mod(r_cfg_warmest);
                    r_lo    <= ccrc_pkg::PCT_TAB[min_pct_c];
                    r_hi    <= ccrc_pkg::PCT_TAB[max_pct_c];
                    r_state <= S_FWD;
                end
                S_FWD: begin
                    r_gap   <= fwd_dist(r_warm, r_cool);
                    r_el    <= fwd_dist(r_warm, r_sod);
                    r_dc    <= fwd_dist(r_cool, r_sod);
                    r_eq    <= r_cool == r_warm;
                    if (r_lo > r_hi) begin
                        r_lo <= r_hi;
                        r_hi <= r_lo;
                    end
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_ramp  <= (r_cfg_ramp < r_gap) ? r_cfg_ramp : r_gap;
                    r_dfold <= (r_dc > HALF) ? DAY - r_dc : r_dc;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    r_hold  <= r_gap - r_ramp;
                    r_state <= S_SELECT;
                end
                S_SELECT: begin
                    if (sel_div) begin
                        r_nq     <= NUM_W'(sel_num) * NUM_W'(TWO_Q);
                        r_den    <= sel_den;
                        r_rem    <= '0;
                        r_rising <= sel_rising;
                        r_cnt    <= CNT_W'(NUM_W - 1);
                        r_state  <= S_DIV;
                    end else begin
                        r_base  <= sel_base;
                        r_state <= S_SCALE;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? SOD_W'(div_t - {1'b0, r_den}) : div_t[SOD_W-1:0];
                    r_nq  <= {r_nq[NUM_W-2:0], div_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FOLD: begin
                    r_q2    <= pos_q2;
                    r_idx   <= IDX_W'(pos_fold >> FRAC_W);
                    r_frac  <= pos_fold[FRAC_W-1:0];
                    r_state <= S_TAB_A;
                end
                S_TAB_A: begin
                    r_ta    <= tab_val;
                    r_state <= S_TAB_B;
                end
                S_TAB_B: begin
                    r_tb    <= tab_val;
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_prod  <= PROD_W'(r_ta - b_min) * PROD_W'(r_frac);
                    r_state <= S_COSV;
                end
                S_COSV: begin
                    r_base  <= base_sum[COS_W:1];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod2 <= PROD2_W'(r_hi - r_lo) * PROD2_W'(r_base);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_q15   <= (q_tmp > QT_W'(ccrc_pkg::RATIO_MAX))
                             ? RW'(ccrc_pkg::RATIO_MAX) : RW'(q_tmp);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Wait here until the output register can take the word.
                    if (slot_free) begin
                        r_out.cool_ratio <= r_q15;
                        r_out.apply      <= apply_now;
                        r_out_valid      <= 1'b1;
                        if (apply_now) begin
                            r_last_ratio   <= r_q15;
                            r_have_applied <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_out_valid && !i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = r_state != S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.cool_ratio <= RW'(ccrc_pkg::RATIO_MAX)))
        else $error("cool ratio above 1.0");

    a_apply_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.apply) |-> (o_data.cool_ratio == r_last_ratio))
        else $error("applied ratio differs from stored last ratio");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule
